### rtl/core/prt_pkg.sv
package prt_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int COEF_WIDTH_DEF  = 16;
    localparam int AXES            = 3;
    localparam int CFG_IDX_W       = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROT_ROW_ONE   = 3'd0,
        REG_ROT_ROW_TWO   = 3'd1,
        REG_ROT_ROW_THREE = 3'd2,
        REG_SHIFT_X       = 3'd3,
        REG_SHIFT_Y       = 3'd4,
        REG_SHIFT_Z       = 3'd5
    } cfg_index_t;

    // forward control that travels with each beat through the pipeline
    typedef struct packed {
        logic valid;
        logic last;
    } pipe_ctl_t;

endpackage

### rtl/core/prt_if.sv
interface point_in_if #(
    parameter int COORD_WIDTH = prt_pkg::COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] local_x;
    logic signed [COORD_WIDTH-1:0] local_y;
    logic signed [COORD_WIDTH-1:0] local_z;
    logic                          last_point;

    modport source (
        output valid, local_x, local_y, local_z, last_point,
        input  ready
    );

    modport sink (
        input  valid, local_x, local_y, local_z, last_point,
        output ready
    );
endinterface

interface point_out_if #(
    parameter int COORD_WIDTH = prt_pkg::COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] global_x;
    logic signed [COORD_WIDTH-1:0] global_y;
    logic signed [COORD_WIDTH-1:0] global_z;
    logic                          clipped;
    logic                          last_out;

    modport source (
        output valid, global_x, global_y, global_z, clipped, last_out,
        input  ready
    );

    modport sink (
        input  valid, global_x, global_y, global_z, clipped, last_out,
        output ready
    );
endinterface

### rtl/core/prt_regs.sv
module prt_regs #(
    parameter int COORD_WIDTH = prt_pkg::COORD_WIDTH_DEF,
    parameter int COEF_WIDTH  = prt_pkg::COEF_WIDTH_DEF,
    localparam int ROW_W      = 3 * COEF_WIDTH,
    localparam int DATA_W     = (ROW_W > COORD_WIDTH) ? ROW_W : COORD_WIDTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  logic [prt_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [DATA_W-1:0]                wr_data,
    output logic [ROW_W-1:0]                 rows   [prt_pkg::AXES],
    output logic signed [COORD_WIDTH-1:0]    shifts [prt_pkg::AXES]
);
    import prt_pkg::*;

    // 1.0 in Q2.14 sits at bit COEF_WIDTH-2 of each coefficient field
    localparam logic [ROW_W-1:0] ONE_LOW = ROW_W'(1) << (COEF_WIDTH - 2);

    logic [ROW_W-1:0]              rows_reg    [AXES];
    logic [ROW_W-1:0]              rows_next   [AXES];
    logic signed [COORD_WIDTH-1:0] shifts_reg  [AXES];
    logic signed [COORD_WIDTH-1:0] shifts_next [AXES];

    always_comb
    begin
        rows_next   = rows_reg;
        shifts_next = shifts_reg;
        if (wr_en)
        begin
            unique case (cfg_index_t'(wr_index))
                REG_ROT_ROW_ONE:   rows_next[0]   = wr_data[ROW_W-1:0];
                REG_ROT_ROW_TWO:   rows_next[1]   = wr_data[ROW_W-1:0];
                REG_ROT_ROW_THREE: rows_next[2]   = wr_data[ROW_W-1:0];
                REG_SHIFT_X:       shifts_next[0] = $signed(wr_data[COORD_WIDTH-1:0]);
                REG_SHIFT_Y:       shifts_next[1] = $signed(wr_data[COORD_WIDTH-1:0]);
                REG_SHIFT_Z:       shifts_next[2] = $signed(wr_data[COORD_WIDTH-1:0]);
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg[0]   <= ONE_LOW << (2 * COEF_WIDTH);
            rows_reg[1]   <= ONE_LOW << COEF_WIDTH;
            rows_reg[2]   <= ONE_LOW;
            shifts_reg[0] <= '0;
            shifts_reg[1] <= '0;
            shifts_reg[2] <= '0;
        end
        else
        begin
            rows_reg   <= rows_next;
            shifts_reg <= shifts_next;
        end
    end

    assign rows   = rows_reg;
    assign shifts = shifts_reg;

    a_row_write: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en && wr_index == REG_ROT_ROW_ONE |=> rows_reg[0] == $past(wr_data[ROW_W-1:0]))
        else $error("row one write lost");

endmodule

### rtl/core/prt_mult.sv
module prt_mult #(
    parameter int COORD_WIDTH = prt_pkg::COORD_WIDTH_DEF,
    parameter int COEF_WIDTH  = prt_pkg::COEF_WIDTH_DEF,
    localparam int ROW_W      = 3 * COEF_WIDTH,
    localparam int PROD_W     = COORD_WIDTH + COEF_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  prt_pkg::pipe_ctl_t            up_ctl,
    output logic                          up_ready,
    input  logic signed [COORD_WIDTH-1:0] pt    [prt_pkg::AXES],
    input  logic [ROW_W-1:0]              rows  [prt_pkg::AXES],
    output prt_pkg::pipe_ctl_t            dn_ctl,
    input  logic                          dn_ready,
    output logic signed [PROD_W-1:0]      prod  [prt_pkg::AXES][prt_pkg::AXES]
);
    import prt_pkg::*;

    pipe_ctl_t                ctl_reg;
    pipe_ctl_t                ctl_next;
    logic signed [PROD_W-1:0] prod_reg  [AXES][AXES];
    logic signed [PROD_W-1:0] prod_next [AXES][AXES];
    logic                     load;

    assign up_ready = !ctl_reg.valid || dn_ready;
    assign load     = up_ctl.valid && up_ready;

    always_comb
    begin
        logic signed [COEF_WIDTH-1:0] coef;
        for (int a = 0; a < AXES; a++)
        begin
            for (int c = 0; c < AXES; c++)
            begin
                coef = $signed(rows[a][(AXES - c) * COEF_WIDTH - 1 -: COEF_WIDTH]);
                prod_next[a][c] = PROD_W'(coef) * PROD_W'(pt[c]);
            end
        end
    end

    always_comb
    begin
        ctl_next = ctl_reg;
        if (up_ready)
        begin
            ctl_next = up_ctl;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= prod_next;
        end
    end

    assign dn_ctl = ctl_reg;
    assign prod   = prod_reg;

endmodule

### rtl/core/prt_add.sv
module prt_add #(
    parameter int COORD_WIDTH = prt_pkg::COORD_WIDTH_DEF,
    parameter int COEF_WIDTH  = prt_pkg::COEF_WIDTH_DEF,
    localparam int PROD_W     = COORD_WIDTH + COEF_WIDTH,
    localparam int SUM_W      = COORD_WIDTH + COEF_WIDTH + 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  prt_pkg::pipe_ctl_t            up_ctl,
    output logic                          up_ready,
    input  logic signed [PROD_W-1:0]      prod    [prt_pkg::AXES][prt_pkg::AXES],
    input  logic signed [COORD_WIDTH-1:0] shifts  [prt_pkg::AXES],
    output prt_pkg::pipe_ctl_t            dn_ctl,
    input  logic                          dn_ready,
    output logic signed [SUM_W-1:0]       part_a  [prt_pkg::AXES],
    output logic signed [SUM_W-1:0]       part_b  [prt_pkg::AXES]
);
    import prt_pkg::*;

    localparam int FRAC = COEF_WIDTH - 2;
    localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) <<< (FRAC - 1);

    pipe_ctl_t               ctl_reg;
    pipe_ctl_t               ctl_next;
    logic signed [SUM_W-1:0] a_reg  [AXES];
    logic signed [SUM_W-1:0] a_next [AXES];
    logic signed [SUM_W-1:0] b_reg  [AXES];
    logic signed [SUM_W-1:0] b_next [AXES];
    logic                    load;

    assign up_ready = !ctl_reg.valid || dn_ready;
    assign load     = up_ctl.valid && up_ready;

    // split the four-term sum; the rounding half rides along with the offset
    always_comb
    begin
        logic signed [SUM_W-1:0] offset;
        for (int a = 0; a < AXES; a++)
        begin
            offset    = SUM_W'(shifts[a]) <<< FRAC;
            a_next[a] = SUM_W'(prod[a][0]) + SUM_W'(prod[a][1]);
            b_next[a] = SUM_W'(prod[a][2]) + offset + HALF;
        end
    end

    always_comb
    begin
        ctl_next = ctl_reg;
        if (up_ready)
        begin
            ctl_next = up_ctl;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
        end
    end

    assign dn_ctl = ctl_reg;
    assign part_a = a_reg;
    assign part_b = b_reg;

endmodule

### rtl/core/prt_sat.sv
module prt_sat #(
    parameter int COORD_WIDTH = prt_pkg::COORD_WIDTH_DEF,
    parameter int COEF_WIDTH  = prt_pkg::COEF_WIDTH_DEF,
    localparam int SUM_W      = COORD_WIDTH + COEF_WIDTH + 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  prt_pkg::pipe_ctl_t            up_ctl,
    output logic                          up_ready,
    input  logic signed [SUM_W-1:0]       part_a  [prt_pkg::AXES],
    input  logic signed [SUM_W-1:0]       part_b  [prt_pkg::AXES],
    output prt_pkg::pipe_ctl_t            dn_ctl,
    input  logic                          dn_ready,
    output logic signed [COORD_WIDTH-1:0] coord   [prt_pkg::AXES],
    output logic                          clipped
);
    import prt_pkg::*;

    localparam int FRAC = COEF_WIDTH - 2;
    localparam logic signed [SUM_W-1:0] MAXV =
        {{(SUM_W - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] MINV =
        {{(SUM_W - COORD_WIDTH + 1){1'b1}}, {(COORD_WIDTH - 1){1'b0}}};
    localparam logic signed [COORD_WIDTH-1:0] CMAX = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] CMIN = {1'b1, {(COORD_WIDTH - 1){1'b0}}};

    pipe_ctl_t                     ctl_reg;
    pipe_ctl_t                     ctl_next;
    logic signed [COORD_WIDTH-1:0] coord_reg  [AXES];
    logic signed [COORD_WIDTH-1:0] coord_next [AXES];
    logic                          clip_reg;
    logic                          clip_next;
    logic                          load;

    assign up_ready = !ctl_reg.valid || dn_ready;
    assign load     = up_ctl.valid && up_ready;

    // floor shift after the half was added gives round half up
    always_comb
    begin
        logic signed [SUM_W-1:0] total;
        logic signed [SUM_W-1:0] scaled;
        clip_next = 1'b0;
        for (int a = 0; a < AXES; a++)
        begin
            total  = part_a[a] + part_b[a];
            scaled = total >>> FRAC;
            if (scaled > MAXV)
            begin
                coord_next[a] = CMAX;
                clip_next     = 1'b1;
            end
            else if (scaled < MINV)
            begin
                coord_next[a] = CMIN;
                clip_next     = 1'b1;
            end
            else
            begin
                coord_next[a] = scaled[COORD_WIDTH-1:0];
            end
        end
    end

    always_comb
    begin
        ctl_next = ctl_reg;
        if (up_ready)
        begin
            ctl_next = up_ctl;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            coord_reg <= coord_next;
            clip_reg  <= clip_next;
        end
    end

    assign dn_ctl  = ctl_reg;
    assign coord   = coord_reg;
    assign clipped = clip_reg;

    a_clip_at_rail: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_reg.valid && clip_reg |->
            coord_reg[0] == CMAX || coord_reg[0] == CMIN ||
            coord_reg[1] == CMAX || coord_reg[1] == CMIN ||
            coord_reg[2] == CMAX || coord_reg[2] == CMIN)
        else $error("clip flag set with no axis at a rail");

endmodule

### rtl/core/point_rigid_transform.sv
// Three registered stages from input beat to result beat: multiply, add, round/saturate.
// One point per cycle unless stalled; nine multipliers work in parallel in stage one.
// Backpressure collapses bubbles; all three stages full and output held stall the input.
// Reset: rst_n asynchronous, active low; clears stage valids, loads the identity
// rotation and zero translation.
module point_rigid_transform #(
    parameter int COORD_WIDTH = prt_pkg::COORD_WIDTH_DEF,
    parameter int COEF_WIDTH  = prt_pkg::COEF_WIDTH_DEF,
    localparam int ROW_W      = 3 * COEF_WIDTH,
    localparam int DATA_W     = (ROW_W > COORD_WIDTH) ? ROW_W : COORD_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    point_in_if.sink                      point,
    point_out_if.source                   result,
    input  logic                          wr_en,
    input  logic [prt_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [DATA_W-1:0]             wr_data
);
    import prt_pkg::*;

    localparam int PROD_W = COORD_WIDTH + COEF_WIDTH;
    localparam int SUM_W  = COORD_WIDTH + COEF_WIDTH + 1;

    logic [ROW_W-1:0]              rows   [AXES];
    logic signed [COORD_WIDTH-1:0] shifts [AXES];
    logic signed [COORD_WIDTH-1:0] pt     [AXES];
    logic signed [PROD_W-1:0]      prod   [AXES][AXES];
    logic signed [SUM_W-1:0]       part_a [AXES];
    logic signed [SUM_W-1:0]       part_b [AXES];
    logic signed [COORD_WIDTH-1:0] coord  [AXES];

    pipe_ctl_t in_ctl;
    pipe_ctl_t mul_ctl;
    pipe_ctl_t add_ctl;
    pipe_ctl_t sat_ctl;
    logic      mul_ready;
    logic      add_ready;
    logic      sat_ready;
    logic      clip;

    assign in_ctl.valid = point.valid;
    assign in_ctl.last  = point.last_point;
    assign pt[0]        = point.local_x;
    assign pt[1]        = point.local_y;
    assign pt[2]        = point.local_z;
    assign point.ready  = mul_ready;

    prt_regs #(
        .COORD_WIDTH (COORD_WIDTH),
        .COEF_WIDTH  (COEF_WIDTH)
    ) u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .rows     (rows),
        .shifts   (shifts)
    );

    prt_mult #(
        .COORD_WIDTH (COORD_WIDTH),
        .COEF_WIDTH  (COEF_WIDTH)
    ) u_mult (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_ctl   (in_ctl),
        .up_ready (mul_ready),
        .pt       (pt),
        .rows     (rows),
        .dn_ctl   (mul_ctl),
        .dn_ready (add_ready),
        .prod     (prod)
    );

    prt_add #(
        .COORD_WIDTH (COORD_WIDTH),
        .COEF_WIDTH  (COEF_WIDTH)
    ) u_add (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_ctl   (mul_ctl),
        .up_ready (add_ready),
        .prod     (prod),
        .shifts   (shifts),
        .dn_ctl   (add_ctl),
        .dn_ready (sat_ready),
        .part_a   (part_a),
        .part_b   (part_b)
    );

    prt_sat #(
        .COORD_WIDTH (COORD_WIDTH),
        .COEF_WIDTH  (COEF_WIDTH)
    ) u_sat (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_ctl   (add_ctl),
        .up_ready (sat_ready),
        .part_a   (part_a),
        .part_b   (part_b),
        .dn_ctl   (sat_ctl),
        .dn_ready (result.ready),
        .coord    (coord),
        .clipped  (clip)
    );

    assign result.valid    = sat_ctl.valid;
    assign result.last_out = sat_ctl.last;
    assign result.global_x = coord[0];
    assign result.global_y = coord[1];
    assign result.global_z = coord[2];
    assign result.clipped  = clip;

    // a draining output frees every stage in the same cycle
    a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
        result.ready |-> point.ready)
        else $error("input stalled while output drains");

    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        point.valid && point.ready && result.ready ##1 result.ready ##1 result.ready
        |=> result.valid)
        else $error("beat did not reach output in three cycles");

endmodule

### tb/point_rigid_transform_tb.sv
module point_rigid_transform_tb;
    import prt_pkg::*;

    localparam int CW          = COORD_WIDTH_DEF;
    localparam int KW          = COEF_WIDTH_DEF;
    localparam int FRAC        = KW - 2;
    localparam int DW          = (3 * KW > CW) ? 3 * KW : CW;
    localparam int LATENCY     = 3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 7;
    localparam int PHASE_ITEMS = 200;

    // indexes past the last register; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    localparam logic [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic [KW-1:0] KMAX = {1'b0, {(KW-1){1'b1}}};
    localparam logic [KW-1:0] KMIN = {1'b1, {(KW-1){1'b0}}};
    localparam logic [KW-1:0] KONE = KW'(1) << FRAC;

    typedef enum int {MIX_RANDOM, MIX_HIGH, MIX_LOW} mix_t;

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [CW-1:0] z;
        logic          last;
    } point_t;

    typedef struct packed {
        logic [CW-1:0] gx;
        logic [CW-1:0] gy;
        logic [CW-1:0] gz;
        logic          clipped;
        logic          last;
    } placed_t;

    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [DW-1:0]        data;
        point_t               pt;
        bit                   typed;
        placed_t              want;
    } step_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 wr_en;
    logic [CFG_IDX_W-1:0] wr_index;
    logic [DW-1:0]        wr_data;

    point_in_if  #(.COORD_WIDTH(CW)) point_bus ();
    point_out_if #(.COORD_WIDTH(CW)) result_bus ();

    point_rigid_transform #(
        .COORD_WIDTH (CW),
        .COEF_WIDTH  (KW)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .point    (point_bus),
        .result   (result_bus),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    logic [3*KW-1:0] row_cfg [3];
    logic [CW-1:0]   shift_cfg [3];
    placed_t         pending_q [$];
    step_t           plan_q [$];
    bit              stall_mode;
    int              fail_count;
    int              points_sent;
    int              results_seen;
    int              reg_writes;
    int              cycle_count;

    always #5 clk = ~clk;

    function automatic placed_t transform_point(point_t p);
        longint          coord [3];
        longint          acc;
        longint          lim_hi;
        longint          lim_lo;
        logic signed [KW-1:0] coef;
        logic [CW-1:0]   axis_out [3];
        logic            clip;
        placed_t         r;
        coord[0] = longint'($signed(p.x));
        coord[1] = longint'($signed(p.y));
        coord[2] = longint'($signed(p.z));
        lim_hi = (longint'(1) <<< (CW - 1)) - 1;
        lim_lo = -lim_hi - 1;
        clip = 1'b0;
        for (int a = 0; a < 3; a++)
        begin
            acc = longint'($signed(shift_cfg[a])) * (longint'(1) <<< FRAC);
            for (int k = 0; k < 3; k++)
            begin
                coef = row_cfg[a][(2 - k) * KW +: KW];
                acc += longint'(coef) * coord[k];
            end
            // floor shift: exact halves go toward plus infinity
            acc = (acc + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
            if (acc > lim_hi)
            begin
                acc  = lim_hi;
                clip = 1'b1;
            end
            if (acc < lim_lo)
            begin
                acc  = lim_lo;
                clip = 1'b1;
            end
            axis_out[a] = acc[CW-1:0];
        end
        r.gx      = axis_out[0];
        r.gy      = axis_out[1];
        r.gz      = axis_out[2];
        r.clipped = clip;
        r.last    = p.last;
        return r;
    endfunction

    function automatic step_t cfg_step(logic [CFG_IDX_W-1:0] idx, logic [DW-1:0] data);
        step_t s;
        s = '{default: '0};
        s.is_cfg = 1'b1;
        s.idx    = idx;
        s.data   = data;
        return s;
    endfunction

    function automatic step_t point_step(logic [CW-1:0] x, logic [CW-1:0] y,
                                         logic [CW-1:0] z, logic last);
        step_t s;
        s = '{default: '0};
        s.pt = '{x, y, z, last};
        return s;
    endfunction

    function automatic step_t known_step(logic [CW-1:0] x, logic [CW-1:0] y,
                                         logic [CW-1:0] z, logic last,
                                         logic [CW-1:0] gx, logic [CW-1:0] gy,
                                         logic [CW-1:0] gz, logic clip);
        step_t s;
        s = point_step(x, y, z, last);
        s.typed = 1'b1;
        s.want  = '{gx, gy, gz, clip, last};
        return s;
    endfunction

    function automatic logic [KW-1:0] pick_coef(mix_t mode);
        if (mode == MIX_HIGH)
            return KMAX;
        if (mode == MIX_LOW)
            return KMIN;
        case ($urandom_range(7))
            0: return KMAX;
            1: return KMIN;
            2: return KONE;
            3: return -KONE;
            4: return '0;
            default: return KW'($urandom);
        endcase
    endfunction

    function automatic logic [CW-1:0] pick_shift(mix_t mode);
        if (mode == MIX_HIGH)
            return CMAX;
        if (mode == MIX_LOW)
            return CMIN;
        case ($urandom_range(5))
            0: return CMAX;
            1: return CMIN;
            2: return '0;
            default: return CW'($urandom);
        endcase
    endfunction

    function automatic logic [CW-1:0] pick_coord();
        case ($urandom_range(9))
            0: return CMAX;
            1: return CMIN;
            2, 3, 4: return CW'($urandom);
            default: return CW'($urandom_range(0, 1 << 21)) - CW'(1 << 20);
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [CW-1:0] got, logic [CW-1:0] want);
        fail_count++;
        if (fail_count <= 50)
            $display("mismatch: %s on beat %0d: got %h, expected %h",
                     what, results_seen, got, want);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DW-1:0] data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        case (idx)
            REG_ROT_ROW_ONE:   row_cfg[0]   = data[3*KW-1:0];
            REG_ROT_ROW_TWO:   row_cfg[1]   = data[3*KW-1:0];
            REG_ROT_ROW_THREE: row_cfg[2]   = data[3*KW-1:0];
            REG_SHIFT_X:       shift_cfg[0] = data[CW-1:0];
            REG_SHIFT_Y:       shift_cfg[1] = data[CW-1:0];
            REG_SHIFT_Z:       shift_cfg[2] = data[CW-1:0];
            default: ;
        endcase
        reg_writes++;
        @(posedge clk);
        wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // hold the input off until the pipeline has emptied
    task automatic settle();
        point_bus.valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic send_point(point_t p, placed_t want);
        while (stall_mode && $urandom_range(99) < 35)
        begin
            point_bus.valid <= 1'b0;
            @(posedge clk);
        end
        point_bus.valid      <= 1'b1;
        point_bus.local_x    <= p.x;
        point_bus.local_y    <= p.y;
        point_bus.local_z    <= p.z;
        point_bus.last_point <= p.last;
        pending_q.push_back(want);
        points_sent++;
        do
            @(negedge clk);
        while (!point_bus.ready);
        @(posedge clk);
    endtask

    task automatic load_transform(mix_t mode);
        settle();
        write_reg(REG_ROT_ROW_ONE,   {pick_coef(mode), pick_coef(mode), pick_coef(mode)});
        write_reg(REG_ROT_ROW_TWO,   {pick_coef(mode), pick_coef(mode), pick_coef(mode)});
        write_reg(REG_ROT_ROW_THREE, {pick_coef(mode), pick_coef(mode), pick_coef(mode)});
        // junk above bit CW must be dropped
        write_reg(REG_SHIFT_X, DW'({$urandom, pick_shift(mode)}));
        write_reg(REG_SHIFT_Y, DW'({$urandom, pick_shift(mode)}));
        write_reg(REG_SHIFT_Z, DW'({$urandom, pick_shift(mode)}));
        if ($urandom_range(1) == 0)
            write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B,
                      DW'({$urandom, $urandom}));
    endtask

    always @(posedge clk)
        result_bus.ready <= !stall_mode || ($urandom_range(99) >= 35);

    always @(negedge clk)
    begin
        placed_t got;
        placed_t want;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            got = '{result_bus.global_x, result_bus.global_y, result_bus.global_z,
                    result_bus.clipped, result_bus.last_out};
            if (pending_q.size() == 0)
                report_mismatch("beat with nothing pending", got.gx, '0);
            else
            begin
                want = pending_q.pop_front();
                if (got.gx !== want.gx)
                    report_mismatch("global_x", got.gx, want.gx);
                if (got.gy !== want.gy)
                    report_mismatch("global_y", got.gy, want.gy);
                if (got.gz !== want.gz)
                    report_mismatch("global_z", got.gz, want.gz);
                if (got.clipped !== want.clipped)
                    report_mismatch("clipped", CW'(got.clipped), CW'(want.clipped));
                if (got.last !== want.last)
                    report_mismatch("last_out", CW'(got.last), CW'(want.last));
            end
            results_seen++;
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d beats still pending",
                 cycle_count, pending_q.size());
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        point_t p;
        rst_n                = 1'b0;
        wr_en                = 1'b0;
        wr_index             = '0;
        wr_data              = '0;
        point_bus.valid      = 1'b0;
        point_bus.local_x    = '0;
        point_bus.local_y    = '0;
        point_bus.local_z    = '0;
        point_bus.last_point = 1'b0;
        result_bus.ready     = 1'b0;
        stall_mode           = 1'b1;
        fail_count           = 0;
        points_sent          = 0;
        results_seen         = 0;
        reg_writes           = 0;
        row_cfg[0]   = {KONE, KW'(0), KW'(0)};
        row_cfg[1]   = {KW'(0), KONE, KW'(0)};
        row_cfg[2]   = {KW'(0), KW'(0), KONE};
        shift_cfg[0] = '0;
        shift_cfg[1] = '0;
        shift_cfg[2] = '0;

        // identity after reset
        plan_q.push_back(known_step(0, 0, 0, 0, 0, 0, 0, 0));
        plan_q.push_back(known_step(1, -1, 2, 1, 1, -1, 2, 0));
        plan_q.push_back(known_step(CMAX, CMIN, CMAX, 0, CMAX, CMIN, CMAX, 0));
        plan_q.push_back(known_step(CMIN, CMAX, CMIN, 1, CMIN, CMAX, CMIN, 0));
        // saturation both ways, upper data bits dropped on shift_z
        plan_q.push_back(cfg_step(REG_SHIFT_X, CMAX));
        plan_q.push_back(cfg_step(REG_SHIFT_Y, CMIN));
        plan_q.push_back(cfg_step(REG_SHIFT_Z, {16'hffff, 32'h0001_2345}));
        plan_q.push_back(known_step(1, -1, 0, 0, CMAX, CMIN, 32'h0001_2345, 1));
        plan_q.push_back(known_step(-1, 1, 0, 1, CMAX - 1, CMIN + 1, 32'h0001_2345, 0));
        // out-of-range indexes are ignored
        plan_q.push_back(cfg_step(REG_SPARE_A, '1));
        plan_q.push_back(cfg_step(REG_SPARE_B, '1));
        plan_q.push_back(known_step(0, 0, 0, 0, CMAX, CMIN, 32'h0001_2345, 0));
        // r11 = 0.5: halves round up, negative halves toward zero
        plan_q.push_back(cfg_step(REG_SHIFT_X, 0));
        plan_q.push_back(cfg_step(REG_SHIFT_Y, 0));
        plan_q.push_back(cfg_step(REG_SHIFT_Z, 0));
        plan_q.push_back(cfg_step(REG_ROT_ROW_ONE, {KONE >> 1, KW'(0), KW'(0)}));
        plan_q.push_back(cfg_step(REG_ROT_ROW_TWO, 0));
        plan_q.push_back(cfg_step(REG_ROT_ROW_THREE, 0));
        plan_q.push_back(known_step(1, 5, 5, 0, 1, 0, 0, 0));
        plan_q.push_back(known_step(-1, 5, 5, 1, 0, 0, 0, 0));
        plan_q.push_back(known_step(3, -5, 5, 0, 2, 0, 0, 0));
        plan_q.push_back(known_step(-3, 5, -5, 1, -1, 0, 0, 0));
        // extreme coefficients and shifts
        plan_q.push_back(cfg_step(REG_ROT_ROW_ONE, {KMIN, KMAX, KMIN}));
        plan_q.push_back(cfg_step(REG_ROT_ROW_TWO, {KMAX, KMAX, KMAX}));
        plan_q.push_back(cfg_step(REG_ROT_ROW_THREE, {KMIN, KMIN, KMIN}));
        plan_q.push_back(cfg_step(REG_SHIFT_X, CMIN));
        plan_q.push_back(cfg_step(REG_SHIFT_Y, CMAX));
        plan_q.push_back(cfg_step(REG_SHIFT_Z, CMIN));
        plan_q.push_back(point_step(CMAX, CMAX, CMAX, 1));
        plan_q.push_back(point_step(CMIN, CMIN, CMIN, 0));
        plan_q.push_back(point_step(CMIN, CMAX, 0, 1));
        plan_q.push_back(point_step(1, -1, 1, 0));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan_q[i])
        begin
            if (plan_q[i].is_cfg)
            begin
                settle();
                write_reg(plan_q[i].idx, plan_q[i].data);
            end
            else
                send_point(plan_q[i].pt,
                           plan_q[i].typed ? plan_q[i].want : transform_point(plan_q[i].pt));
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            load_transform(phase == 0 ? MIX_HIGH : (phase == 1 ? MIX_LOW : MIX_RANDOM));
            stall_mode = (phase != 3);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(149) == 0)
                    settle();
                p = '{pick_coord(), pick_coord(), pick_coord(), ($urandom_range(7) == 0)};
                send_point(p, transform_point(p));
            end
        end
        stall_mode = 1'b1;
        settle();

        $display("%0d points over %0d register writes, extreme and random transforms",
                 points_sent, reg_writes);
        $display("%0d result beats checked, %0d mismatches", results_seen, fail_count);
        if (fail_count == 0 && pending_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### point_rigid_transform.f
rtl/core/prt_pkg.sv
rtl/core/prt_if.sv
rtl/core/prt_regs.sv
rtl/core/prt_mult.sv
rtl/core/prt_add.sv
rtl/core/prt_sat.sv
rtl/core/point_rigid_transform.sv
tb/point_rigid_transform_tb.sv
